// ===== design/double_ended_ring_queue_macros.svh =====
// Assertion macros shared by the double-ended ring queue modules.
`ifndef DOUBLE_ENDED_RING_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_RING_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DERQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DERQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/derq_pkg.sv =====
// Package with the operation and status codes of the double-ended ring queue.
`default_nettype none

package derq_pkg;

    // Operation codes carried in the mode field of a command beat.
    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_READ_AT    = 3'd4,
        MODE_CLEAR      = 3'd5
    } mode_t;

    // Status codes carried in the status field of a response beat.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // An operation handed from the control unit to the response stage.
    typedef struct packed {
        logic    valid;
        logic    use_ram;
        status_t status;
    } issue_t;

endpackage

`default_nettype wire

// ===== design/derq_if.sv =====
// Command and response channel interfaces of the double-ended ring queue.
`default_nettype none

interface derq_cmd_if #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
);
    localparam int SLOT_W = $clog2(DEPTH);

    logic                  valid;
    logic                  ready;
    logic [2:0]            mode;
    logic [DATA_WIDTH-1:0] write_data;
    logic [SLOT_W-1:0]     index;

    modport source (output valid, mode, write_data, index, input ready);
    modport sink   (input valid, mode, write_data, index, output ready);
endinterface

interface derq_rsp_if #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] read_data;
    logic [COUNT_W-1:0]    fill_level;

    modport source (output valid, status, read_data, fill_level, input ready);
    modport sink   (input valid, status, read_data, fill_level, output ready);
endinterface

`default_nettype wire

// ===== design/derq_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module derq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle; the read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/derq_ctrl.sv =====
// Control unit: head slot, fill count and RAM access for each operation.
`default_nettype none

`include "double_ended_ring_queue_macros.svh"

module derq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           take,
    input  wire logic [2:0]                     mode,
    input  wire logic [DATA_WIDTH-1:0]          write_data,
    input  wire logic [$clog2(DEPTH)-1:0]       index,
    output      logic                           ram_en,
    output      logic                           ram_we,
    output      logic [$clog2(DEPTH)-1:0]       ram_addr,
    output      logic [DATA_WIDTH-1:0]          ram_wdata,
    output      derq_pkg::issue_t               issue,
    output      logic [$clog2(DEPTH + 1)-1:0]   fill
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [SLOT_W-1:0]  head_reg;
    logic [SLOT_W-1:0]  head_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] last_pos;
    logic               full;
    logic               empty;
    derq_pkg::status_t  status;
    logic               use_ram;

    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_pos = count_reg - 1'b1;

    // Decode the operation, pick the slot and work out the new head and count.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = head_reg;
        status     = derq_pkg::STATUS_OK;
        use_ram    = 1'b0;
        if (take)
        begin
            unique case (derq_pkg::mode_t'(mode))
                derq_pkg::MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status = derq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_addr   = head_reg + count_reg[SLOT_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                derq_pkg::MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status = derq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_addr   = head_reg - 1'b1;
                        head_next  = head_reg - 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                derq_pkg::MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status = derq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        use_ram    = 1'b1;
                        ram_addr   = head_reg;
                        head_next  = head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                derq_pkg::MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status = derq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        use_ram    = 1'b1;
                        ram_addr   = head_reg + last_pos[SLOT_W-1:0];
                        count_next = count_reg - 1'b1;
                    end
                end
                derq_pkg::MODE_READ_AT:
                begin
                    if (COUNT_W'(index) >= count_reg)
                    begin
                        status = derq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_en   = 1'b1;
                        use_ram  = 1'b1;
                        ram_addr = head_reg + index;
                    end
                end
                derq_pkg::MODE_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Head slot and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign ram_wdata      = write_data;
    assign issue.valid    = take;
    assign issue.use_ram  = use_ram;
    assign issue.status   = status;
    assign fill           = count_next;

    `DERQ_ASSERT_SAME(a_count_in_range, clk, rst_n, 1'b1, count_reg <= COUNT_W'(DEPTH),
        "fill count exceeds the capacity")
    `DERQ_ASSERT_SAME(a_no_write_when_full, clk, rst_n, ram_en && ram_we, !full,
        "RAM write issued while the queue is full")
    `DERQ_ASSERT_NEXT(a_push_grows, clk, rst_n,
        ram_en && ram_we, count_reg == $past(count_reg) + 1'b1,
        "push did not grow the fill count by one")

endmodule

`default_nettype wire

// ===== design/derq_resp.sv =====
// Response stage: waits for the RAM read and holds the response beat.
`default_nettype none

`include "double_ended_ring_queue_macros.svh"

module derq_resp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire derq_pkg::issue_t             issue,
    input  wire logic [$clog2(DEPTH + 1)-1:0] fill,
    input  wire logic [DATA_WIDTH-1:0]        ram_rdata,
    output      logic                         can_take,
    derq_rsp_if.source                        rsp
);

    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic                  pend_use_reg;
    derq_pkg::status_t     pend_status_reg;
    logic [COUNT_W-1:0]    pend_fill_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    derq_pkg::status_t     out_status_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [COUNT_W-1:0]    out_fill_reg;
    logic                  out_load;

    // The pending operation moves to the output register once that is free.
    assign out_load = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign can_take = !pend_valid_reg || out_load;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (issue.valid)
        begin
            pend_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags of the pending and output stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the pending and output stages.
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            pend_use_reg    <= issue.use_ram;
            pend_status_reg <= issue.status;
            pend_fill_reg   <= fill;
        end
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_use_reg ? ram_rdata : '0;
            out_fill_reg   <= pend_fill_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.fill_level = out_fill_reg;

    `DERQ_ASSERT_SAME(a_no_issue_when_blocked, clk, rst_n,
        pend_valid_reg && !out_load, !issue.valid,
        "operation issued while the pending stage is blocked")
    `DERQ_ASSERT_SAME(a_error_reads_zero, clk, rst_n,
        out_valid_reg && (out_status_reg != derq_pkg::STATUS_OK), out_data_reg == '0,
        "failed operation returned nonzero data")

endmodule

`default_nettype wire

// ===== design/double_ended_ring_queue.sv =====
// Top level of the double-ended ring queue.
//
// The queue holds up to DEPTH elements of DATA_WIDTH bits in a circular RAM.
// Each beat on the cmd channel is one operation: push back, push front,
// pop front, pop back, read at a logical index from the front, or clear.
// Every operation produces exactly one beat on the rsp channel with a status
// (ok, empty or index out of range, full), the data popped or read (zero
// otherwise) and the fill level after the operation.
// The RAM access and the pending stage both register at the accept edge, and
// the output register loads from them once it is free, and the response beat
// is taken from the output register. The head slot and fill count update at
// accept, so a new command is taken every cycle while the receiver keeps up,
// for a throughput of one operation per cycle, set by the single RAM port
// that serves one read or one write per cycle.
// Reset empties the queue at once; the RAM contents are not cleared and are
// never returned before being written. When the receiver stalls, the response
// waits in the output register, one more operation waits for it, and cmd.ready
// drops until the output register frees up.
`default_nettype none

module double_ended_ring_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    derq_cmd_if.sink  cmd,
    derq_rsp_if.source rsp
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic                  can_take;
    logic                  take;
    logic                  ram_en;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    derq_pkg::issue_t      issue;
    logic [COUNT_W-1:0]    fill;

    assign cmd.ready = can_take;
    assign take      = cmd.valid && can_take;

    derq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .mode       (cmd.mode),
        .write_data (cmd.write_data),
        .index      (cmd.index),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .issue      (issue),
        .fill       (fill)
    );

    derq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    derq_resp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .fill      (fill),
        .ram_rdata (ram_rdata),
        .can_take  (can_take),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/double_ended_ring_queue_tb.sv =====
// Self-checking testbench for the double-ended ring queue.
module double_ended_ring_queue_tb;

    localparam int DEPTH         = 16;
    localparam int DATA_WIDTH    = 32;
    localparam int SLOT_W        = $clog2(DEPTH);
    localparam int COUNT_W       = $clog2(DEPTH + 1);
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_OPS    = 1600;
    localparam int HOLD_AT       = 400;
    localparam int DRAIN_AT      = 900;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIR_ROWS      = 16;

    // Mode codes with no operation behind them.
    localparam logic [2:0] MODE_RSVD_A = 3'd6;
    localparam logic [2:0] MODE_RSVD_B = 3'd7;

    typedef enum logic [1:0] {
        LOAD_FILL,
        LOAD_DRAIN,
        LOAD_MIXED
    } load_bias_t;

    typedef struct packed {
        logic [2:0]            mode;
        logic [DATA_WIDTH-1:0] data;
        logic [SLOT_W-1:0]     index;
    } op_t;

    typedef struct packed {
        derq_pkg::status_t     status;
        logic [DATA_WIDTH-1:0] read_data;
        logic [COUNT_W-1:0]    fill_level;
    } rsp_t;

    // One row of the directed table; pinned rows carry a hand-written result.
    typedef struct packed {
        logic [2:0]            mode;
        logic [DATA_WIDTH-1:0] data;
        logic [SLOT_W-1:0]     index;
        logic [4:0]            reps;
        logic                  pinned;
        derq_pkg::status_t     want_status;
        logic [DATA_WIDTH-1:0] want_data;
        logic [COUNT_W-1:0]    want_fill;
    } dir_row_t;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{derq_pkg::MODE_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_POP_BACK,   32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_READ_AT,    32'h0000_0000, 4'd15, 5'd1,  1'b1,
          derq_pkg::STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{MODE_RSVD_A,               32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{MODE_RSVD_B,               32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd1},
        '{derq_pkg::MODE_PUSH_BACK,  32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd2},
        '{derq_pkg::MODE_READ_AT,    32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'hFFFF_FFFF, 5'd2},
        '{derq_pkg::MODE_PUSH_FRONT, 32'h5A5A_0000, 4'd0,  5'd14, 1'b0,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_PUSH_BACK,  32'h0000_0001, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_FULL,  32'h0000_0000, 5'd16},
        '{derq_pkg::MODE_PUSH_FRONT, 32'h0000_0002, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_FULL,  32'h0000_0000, 5'd16},
        '{derq_pkg::MODE_READ_AT,    32'h0000_0000, 4'd15, 5'd1,  1'b0,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_POP_BACK,   32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd15},
        '{derq_pkg::MODE_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1,  1'b0,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_CLEAR,      32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_OK,    32'h0000_0000, 5'd0},
        '{derq_pkg::MODE_READ_AT,    32'h0000_0000, 4'd0,  5'd1,  1'b1,
          derq_pkg::STATUS_EMPTY, 32'h0000_0000, 5'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    derq_cmd_if #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) cmd ();
    derq_rsp_if #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) rsp ();

    double_ended_ring_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Shadow copy of the queue contents, head and fill count.
    logic [DATA_WIDTH-1:0] mirror_store [DEPTH];
    logic [SLOT_W-1:0]     mirror_head  = '0;
    logic [COUNT_W-1:0]    mirror_count = '0;

    // Responses still owed by the block, oldest first.
    rsp_t pending_rsp [$];

    // Hand-written result travelling alongside the current command beat.
    logic pin_result;
    rsp_t pin_value;

    bit long_hold_pending = 1'b0;

    int fail_count   = 0;
    int checked_rsp  = 0;
    int directed_ops = 0;
    int random_ops   = 0;
    int full_seen    = 0;
    int missing_seen = 0;
    int clear_seen   = 0;
    int cycle_count  = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Apply one operation to the shadow queue and return the response it owes.
    function automatic rsp_t deque_outcome(input op_t op);
        rsp_t              res;
        logic [SLOT_W-1:0] slot;
        res.status    = derq_pkg::STATUS_OK;
        res.read_data = '0;
        case (op.mode)
            derq_pkg::MODE_PUSH_BACK:
            begin
                if (mirror_count == DEPTH)
                    res.status = derq_pkg::STATUS_FULL;
                else
                begin
                    slot = mirror_head + mirror_count[SLOT_W-1:0];
                    mirror_store[slot] = op.data;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            derq_pkg::MODE_PUSH_FRONT:
            begin
                if (mirror_count == DEPTH)
                    res.status = derq_pkg::STATUS_FULL;
                else
                begin
                    mirror_head = mirror_head - 1'b1;
                    mirror_store[mirror_head] = op.data;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            derq_pkg::MODE_POP_FRONT:
            begin
                if (mirror_count == 0)
                    res.status = derq_pkg::STATUS_EMPTY;
                else
                begin
                    res.read_data = mirror_store[mirror_head];
                    mirror_head = mirror_head + 1'b1;
                    mirror_count = mirror_count - 1'b1;
                end
            end
            derq_pkg::MODE_POP_BACK:
            begin
                if (mirror_count == 0)
                    res.status = derq_pkg::STATUS_EMPTY;
                else
                begin
                    mirror_count = mirror_count - 1'b1;
                    slot = mirror_head + mirror_count[SLOT_W-1:0];
                    res.read_data = mirror_store[slot];
                end
            end
            derq_pkg::MODE_READ_AT:
            begin
                if ({1'b0, op.index} >= mirror_count)
                    res.status = derq_pkg::STATUS_EMPTY;
                else
                begin
                    slot = mirror_head + op.index;
                    res.read_data = mirror_store[slot];
                end
            end
            derq_pkg::MODE_CLEAR:
            begin
                mirror_head  = '0;
                mirror_count = '0;
            end
            default:
            begin
            end
        endcase
        res.fill_level = mirror_count;
        return res;
    endfunction

    // Draw one random operation, leaning toward pushes or pops by the bias.
    function automatic op_t pick_op(input load_bias_t bias);
        op_t         op;
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned read_pct;
        case (bias)
            LOAD_FILL:
            begin
                push_pct = 62;
                pop_pct  = 15;
                read_pct = 20;
            end
            LOAD_DRAIN:
            begin
                push_pct = 15;
                pop_pct  = 62;
                read_pct = 20;
            end
            default:
            begin
                push_pct = 35;
                pop_pct  = 33;
                read_pct = 26;
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            op.data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
            op.data = $urandom;
        if ($urandom_range(0, 1) != 0)
            op.index = SLOT_W'($urandom_range(0, 15));
        else
            op.index = SLOT_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            op.mode = $urandom_range(0, 1) ? derq_pkg::MODE_PUSH_FRONT
                                           : derq_pkg::MODE_PUSH_BACK;
        else if (roll < push_pct + pop_pct)
            op.mode = $urandom_range(0, 1) ? derq_pkg::MODE_POP_FRONT
                                           : derq_pkg::MODE_POP_BACK;
        else if (roll < push_pct + pop_pct + read_pct)
            op.mode = derq_pkg::MODE_READ_AT;
        else if (roll < 98)
            op.mode = derq_pkg::MODE_CLEAR;
        else
            op.mode = $urandom_range(0, 1) ? MODE_RSVD_A : MODE_RSVD_B;
        return op;
    endfunction

    // Offer one command beat after an optional idle gap and wait for acceptance.
    task automatic send_beat(input op_t op, input logic pinned, input rsp_t want,
                             input int gap);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.mode       <= op.mode;
        cmd.write_data <= op.data;
        cmd.index      <= op.index;
        pin_result     <= pinned;
        pin_value      <= want;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Compare each response beat with the oldest owed result, then log new commands.
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        op_t  taken;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    fail_count++;
                    $error("response beat with nothing owed: status %0d read_data 0x%08h %s %0d",
                           rsp.status, rsp.read_data, "fill_level", rsp.fill_level);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    checked_rsp++;
                    if (rsp.status !== want.status)
                    begin
                        fail_count++;
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                    end
                    if (rsp.read_data !== want.read_data)
                    begin
                        fail_count++;
                        $error("read_data: expected 0x%08h, got 0x%08h",
                               want.read_data, rsp.read_data);
                    end
                    if (rsp.fill_level !== want.fill_level)
                    begin
                        fail_count++;
                        $error("fill_level: expected %0d, got %0d",
                               want.fill_level, rsp.fill_level);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                taken.mode  = cmd.mode;
                taken.data  = cmd.write_data;
                taken.index = cmd.index;
                want = deque_outcome(taken);
                if (pin_result)
                    want = pin_value;
                if (want.status == derq_pkg::STATUS_FULL)
                    full_seen++;
                if (want.status == derq_pkg::STATUS_EMPTY)
                    missing_seen++;
                if (taken.mode == derq_pkg::MODE_CLEAR)
                    clear_seen++;
                pending_rsp.push_back(want);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Response side: a stall pattern picked at random for each stretch,
    // plus one long hold-off on request from the command side.
    initial
    begin : receiver
        int style;
        int span;
        bit toggle;
        rsp.ready = 1'b0;
        toggle    = 1'b0;
        wait (rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 120);
            repeat (span)
            begin
                @(negedge clk);
                if (long_hold_pending)
                begin
                    long_hold_pending = 1'b0;
                    rsp.ready <= 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else
                begin
                    case (style)
                        0: rsp.ready <= 1'b1;
                        1: rsp.ready <= ($urandom_range(0, 9) < 7);
                        2: rsp.ready <= ($urandom_range(0, 9) < 3);
                        default:
                        begin
                            toggle = ~toggle;
                            rsp.ready <= toggle;
                        end
                    endcase
                end
            end
        end
    end

    // Command side: directed table first, then biased random traffic in bursts.
    initial
    begin : stimulus
        op_t        op;
        rsp_t       want;
        rsp_t       no_pin;
        load_bias_t bias;
        int         bias_left;
        int         burst_left;
        int         gap;
        cmd.valid      = 1'b0;
        cmd.mode       = derq_pkg::MODE_PUSH_BACK;
        cmd.write_data = '0;
        cmd.index      = '0;
        pin_result     = 1'b0;
        pin_value      = '0;
        no_pin         = '0;
        bias           = LOAD_MIXED;
        bias_left      = 0;
        burst_left     = 0;
        wait (rst_n);
        @(negedge clk);

        // Directed rows: empty and full corners, wrap of the head, clear, unused modes.
        foreach (dir_table[r])
        begin
            for (int k = 0; k < dir_table[r].reps; k++)
            begin
                op.mode  = dir_table[r].mode;
                op.data  = dir_table[r].data ^ k;
                op.index = dir_table[r].index;
                want.status     = dir_table[r].want_status;
                want.read_data  = dir_table[r].want_data;
                want.fill_level = dir_table[r].want_fill;
                send_beat(op, dir_table[r].pinned, want, 0);
                directed_ops++;
            end
        end

        // Random traffic with fill, drain and mixed stretches.
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (bias_left == 0)
            begin
                bias      = load_bias_t'($urandom_range(0, 2));
                bias_left = $urandom_range(10, 60);
            end
            bias_left--;
            if (n == HOLD_AT)
                long_hold_pending = 1'b1;
            // Let the block drain completely once before carrying on.
            if (n == DRAIN_AT)
            begin
                cmd.valid <= 1'b0;
                @(negedge clk);
                while (pending_rsp.size() != 0)
                    @(negedge clk);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap        = $urandom_range(1, 8);
            end
            else
                gap = 0;
            burst_left--;
            send_beat(pick_op(bias), 1'b0, no_pin, gap);
            random_ops++;
        end

        cmd.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d operations (%0d directed, %0d random); %0d responses checked.",
                 directed_ops + random_ops, directed_ops, random_ops, checked_rsp);
        $display("Saw %0d pushes into a full queue, %0d empty or out-of-range, %0d clears.",
                 full_seen, missing_seen, clear_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
